### rtl/core/upn_pkg.sv
// ----------------------------------------------------------------------------
// upn_pkg: shared types and helpers for the URL percent normalizer
// Token format passed from the classifier to the encoder, queue status,
// decode state codes and the character helpers used on both sides.
// ----------------------------------------------------------------------------
package upn_pkg;

	// queue depth between front and back
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// character constants
	localparam logic [7:0] CH_PCT  = 8'h25;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] HEX_LETTER_BASE = 8'd55;
	localparam logic [7:0] HEX_DIGIT_BASE  = 8'd48;

	// decode state: how much of a %XX triple is held
	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_PCT  = 2'd1,
		PEND_HEX  = 2'd2
	} pend_t;

	// one unit of work for the encoder: a decoded byte or a bare end marker
	typedef struct packed {
		logic [7:0] data;
		logic       marker;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n > 4'd9) ? ({4'd0, n} + HEX_LETTER_BASE) : ({4'd0, n} + HEX_DIGIT_BASE);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	// C-locale whitespace: space, TAB, LF, VT, FF, CR
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

### rtl/core/url_percent_normalizer_unit.sv
// ----------------------------------------------------------------------------
// url_percent_normalizer_unit: streaming URL percent re-encoder
// Decodes %XX triples in a byte stream and re-encodes every byte in
// form-urlencoded style, one output character per transfer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, in_byte, in_last      | in
//  output  | out_valid, out_stall, out_byte,           | out
//          | byte_valid, out_last                      |
//
//  The classifier takes one byte per cycle once its token buffer is empty
//  or its last token is pushed; each byte yields zero to three tokens,
//  pushed one per cycle unless the queue is full. The encoder emits one
//  character per cycle unless stalled; a byte yields 0 to 7 characters.
//  A four-entry token queue lets input and output stall independently.
//  Reset clears the decode state, queue pointers and valid flags.
// ----------------------------------------------------------------------------
module url_percent_normalizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       out_last
);
	import upn_pkg::*;

	logic       push;
	logic       pop;
	tok_t       push_tok;
	tok_t       head;
	fifo_stat_t fstat;

	upn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.in_stall (in_stall),
		.push     (push),
		.push_tok (push_tok),
		.fstat    (fstat)
	);

	upn_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.pop      (pop),
		.head     (head),
		.stat     (fstat)
	);

	upn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fstat      (fstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last),
		.out_stall  (out_stall)
	);

	// queue never overflows or underflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fstat.full)
		else $error("token pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fstat.empty)
		else $error("token popped from empty queue");

	// a bare end marker is always a zero byte closing the string
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (out_last && out_byte == CH_NUL))
		else $error("malformed end marker");

endmodule

### rtl/core/upn_front.sv
// ----------------------------------------------------------------------------
// upn_front: input classifier
// Accepts input bytes, runs the %XX decode state machine and turns each
// byte into zero to three tokens, pushed one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module upn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               in_stall,
	output logic               push,
	output upn_pkg::tok_t      push_tok,
	input  upn_pkg::fifo_stat_t fstat
);
	import upn_pkg::*;

	pend_t      pend_q, pend_d, pend_nx;
	logic [7:0] first_q, first_d;
	logic       trunc_q, trunc_d;
	tok_t       tok_q [3];
	logic [1:0] cnt_q;
	tok_t       nt [3];
	logic [1:0] n;
	logic       accept;
	logic       busy;

	assign busy     = (cnt_q != 2'd0);
	assign push     = busy && !fstat.full;
	assign push_tok = tok_q[0];
	assign in_stall = busy && !(push && cnt_q == 2'd1);
	assign accept   = in_valid && !in_stall;

	// decode step and token list for the presented byte
	always_comb begin
		pend_t      p;
		logic [7:0] d;
		p       = pend_q;
		d       = {hex_value(first_q), hex_value(in_byte)};
		pend_d  = pend_q;
		first_d = first_q;
		trunc_d = trunc_q;
		n       = 2'd0;
		for (int i = 0; i < 3; i++) begin
			nt[i] = '{data: CH_NUL, marker: 1'b0, last: 1'b0};
		end
		if (!trunc_q) begin
			if (in_byte == CH_NUL) begin
				// terminator: flush held characters as literals
				if (p != PEND_NONE) begin
					nt[n].data = CH_PCT;
					n = n + 2'd1;
				end
				if (p == PEND_HEX) begin
					nt[n].data = first_q;
					n = n + 2'd1;
				end
				pend_d  = PEND_NONE;
				trunc_d = 1'b1;
			end else begin
				unique case (p)
					PEND_PCT: begin
						if (is_hex(in_byte)) begin
							first_d = in_byte;
							pend_d  = PEND_HEX;
						end else begin
							nt[n].data = CH_PCT;
							n = n + 2'd1;
							pend_d = PEND_NONE;
							if (in_byte == CH_PCT) begin
								pend_d = PEND_PCT;
							end else begin
								nt[n].data = in_byte;
								n = n + 2'd1;
							end
						end
					end
					PEND_HEX: begin
						if (is_hex(in_byte)) begin
							pend_d = PEND_NONE;
							if (d == CH_NUL) begin
								trunc_d = 1'b1;
							end else begin
								nt[n].data = d;
								n = n + 2'd1;
							end
						end else begin
							nt[n].data = CH_PCT;
							n = n + 2'd1;
							nt[n].data = first_q;
							n = n + 2'd1;
							pend_d = PEND_NONE;
							if (in_byte == CH_PCT) begin
								pend_d = PEND_PCT;
							end else begin
								nt[n].data = in_byte;
								n = n + 2'd1;
							end
						end
					end
					default: begin
						if (in_byte == CH_PCT) begin
							pend_d = PEND_PCT;
						end else begin
							nt[n].data = in_byte;
							n = n + 2'd1;
						end
					end
				endcase
			end
		end
		// end of string: flush, mark the last token, clear state
		if (in_last) begin
			if (!trunc_d) begin
				if (pend_d != PEND_NONE) begin
					nt[n].data = CH_PCT;
					n = n + 2'd1;
				end
				if (pend_d == PEND_HEX) begin
					nt[n].data = first_d;
					n = n + 2'd1;
				end
			end
			if (n == 2'd0) begin
				nt[0] = '{data: CH_NUL, marker: 1'b1, last: 1'b1};
				n = 2'd1;
			end else begin
				nt[n - 2'd1].last = 1'b1;
			end
			pend_d  = PEND_NONE;
			first_d = CH_NUL;
			trunc_d = 1'b0;
		end
	end

	// next state of the decode state machine
	always_comb begin
		pend_nx = accept ? pend_d : pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
		end else begin
			pend_q <= pend_nx;
		end
	end

	// held digit, truncation flag and token buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= CH_NUL;
			trunc_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else begin
			if (accept) begin
				first_q <= first_d;
				trunc_q <= trunc_d;
				cnt_q   <= n;
			end else if (push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q <= nt;
		end else if (push) begin
			tok_q[0] <= tok_q[1];
			tok_q[1] <= tok_q[2];
		end
	end

endmodule

### rtl/core/upn_fifo.sv
// ----------------------------------------------------------------------------
// upn_fifo: token queue
// Short first-in first-out queue that decouples the classifier from the
// encoder, so each side stalls on its own.
// ----------------------------------------------------------------------------
module upn_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upn_pkg::tok_t       push_tok,
	input  logic                pop,
	output upn_pkg::tok_t       head,
	output upn_pkg::fifo_stat_t stat
);
	import upn_pkg::*;

	tok_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign head       = mem_q[rp_q];
	assign stat.full  = (cnt_q == (QAW + 1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_tok;
		end
	end

endmodule

### rtl/core/upn_back.sv
// ----------------------------------------------------------------------------
// upn_back: token encoder
// Pops tokens and emits one character per cycle unless stalled: letters and
// digits as is, whitespace '+', markers NUL, else '%' and two hex digits.
// ----------------------------------------------------------------------------
module upn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  upn_pkg::tok_t       head,
	input  upn_pkg::fifo_stat_t fstat,
	output logic                pop,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                out_last,
	input  logic                out_stall
);
	import upn_pkg::*;

	tok_t       cur_q;
	logic       cur_v_q;
	logic [1:0] pos_q;
	logic       out_v_q;
	logic [7:0] obyte_q;
	logic       obv_q;
	logic       olast_q;
	logic       three;
	logic       fin;
	logic       advance;
	logic [7:0] ch;

	// character selection for the current token
	always_comb begin
		three = !cur_q.marker && !is_alnum(cur_q.data) && !is_space(cur_q.data);
		fin   = !three || (pos_q == 2'd2);
		if (cur_q.marker) begin
			ch = CH_NUL;
		end else if (is_alnum(cur_q.data)) begin
			ch = cur_q.data;
		end else if (is_space(cur_q.data)) begin
			ch = CH_PLUS;
		end else begin
			case (pos_q)
				2'd0:    ch = CH_PCT;
				2'd1:    ch = nibble_char(cur_q.data[7:4]);
				default: ch = nibble_char(cur_q.data[3:0]);
			endcase
		end
	end

	assign advance = cur_v_q && (!out_v_q || !out_stall);
	assign pop     = !fstat.empty && (!cur_v_q || (advance && fin));

	// current token and character position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			pos_q   <= 2'd0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
			end else if (advance && fin) begin
				cur_v_q <= 1'b0;
			end
			if (advance) begin
				pos_q <= fin ? 2'd0 : pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			obyte_q <= ch;
			obv_q   <= !cur_q.marker;
			olast_q <= cur_q.last && fin;
		end
	end

	assign out_valid  = out_v_q;
	assign out_byte   = obyte_q;
	assign byte_valid = obv_q;
	assign out_last   = olast_q;

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: URL percent normalizer unit
// Feeds byte strings into the normalizer with random gaps on the input side
// and random stalls on the output side. A directed table covers the edge
// cases, then random strings mixing %XX triples and other bytes follow. Every
// output transfer is checked against the table's expected characters or a
// behavioral model of the decode and re-encode passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import upn_pkg::*;

	localparam int RAND_ITEMS  = 245;
	localparam int IDLE_LIMIT  = 1000;
	localparam int DRAIN_TICKS = 32;

	// how the expected output of a stimulus row is obtained
	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_CHARS,
		ROW_MARKER
	} row_kind_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        l;
		row_kind_t   kind;
		logic [2:0]  n;
		logic [55:0] chars;
	} stim_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       vld;
		logic       lst;
	} enc_res_t;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       out_last;

	// model state
	pend_t      pend_st     = PEND_NONE;
	logic [7:0] held_digit  = 8'h00;
	logic       trunc_st    = 1'b0;
	enc_res_t   step_buf [7];
	int         step_n;

	enc_res_t   expected_chars [$];
	stim_t      dir_tab [25];
	stim_t      rand_q [$];
	stim_t      cur_item;
	int         mismatches = 0;
	logic       calm       = 1'b0;
	logic       drain_on   = 1'b0;

	url_percent_normalizer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.out_last   (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- model of the decode and re-encode passes ----------------

	function automatic logic hex_digit_ok(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
	endfunction

	function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= "0" && c <= "9") begin
			v = c - "0";
		end else if (c >= "A" && c <= "F") begin
			v = c - "A" + 8'd10;
		end else begin
			v = c - "a" + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] nibble_to_char(input logic [3:0] n);
		return (n > 4'd9) ? ({4'd0, n} + HEX_LETTER_BASE) : ({4'd0, n} + HEX_DIGIT_BASE);
	endfunction

	// at most seven characters per input byte
	task automatic emit_char(input logic [7:0] c);
		if (step_n < 7) begin
			step_buf[step_n] = {c, 1'b1, 1'b0};
			step_n++;
		end
	endtask

	task automatic encode_char(input logic [7:0] c);
		logic alnum;
		logic space;
		alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		space = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
		if (alnum) begin
			emit_char(c);
		end else if (space) begin
			emit_char(CH_PLUS);
		end else begin
			emit_char(CH_PCT);
			emit_char(nibble_to_char(c[7:4]));
			emit_char(nibble_to_char(c[3:0]));
		end
	endtask

	// held '%' and digit go out as literals
	task automatic flush_held();
		if (pend_st == PEND_PCT || pend_st == PEND_HEX)
			encode_char(CH_PCT);
		if (pend_st == PEND_HEX)
			encode_char(held_digit);
		pend_st = PEND_NONE;
	endtask

	task automatic plain_char(input logic [7:0] c);
		if (c == CH_PCT)
			pend_st = PEND_PCT;
		else
			encode_char(c);
	endtask

	// fills step_buf with the characters one input byte yields
	task automatic predict_step(input logic [7:0] b, input logic lst);
		logic [7:0] d;
		step_n = 0;
		if (!trunc_st) begin
			if (b == CH_NUL) begin
				// a zero byte acts as a terminator
				flush_held();
				trunc_st = 1'b1;
			end else begin
				case (pend_st)
					PEND_PCT: begin
						if (hex_digit_ok(b)) begin
							held_digit = b;
							pend_st = PEND_HEX;
						end else begin
							flush_held();
							plain_char(b);
						end
					end
					PEND_HEX: begin
						if (hex_digit_ok(b)) begin
							d = {hex_digit_val(held_digit), hex_digit_val(b)};
							pend_st = PEND_NONE;
							if (d == CH_NUL)
								trunc_st = 1'b1;
							else
								encode_char(d);
						end else begin
							flush_held();
							plain_char(b);
						end
					end
					default: plain_char(b);
				endcase
			end
		end
		if (lst) begin
			if (!trunc_st)
				flush_held();
			if (step_n == 0) begin
				step_buf[0] = {CH_NUL, 1'b0, 1'b1};
				step_n = 1;
			end else begin
				step_buf[step_n - 1].lst = 1'b1;
			end
			pend_st = PEND_NONE;
			held_digit = 8'h00;
			trunc_st = 1'b0;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic stim_t row(input logic [7:0] b, input logic l, input row_kind_t k,
			input int n, input logic [55:0] c);
		stim_t s;
		s.b = b;
		s.l = l;
		s.kind = k;
		s.n = n[2:0];
		s.chars = c;
		return s;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_hex_char(input logic [3:0] n);
		if (n > 4'd9)
			return ($urandom_range(0, 1) ? "a" : "A") + {4'd0, n} - 8'd10;
		else
			return "0" + {4'd0, n};
	endfunction

	task automatic push_rand(input logic [7:0] b);
		rand_q.push_back(row(b, 1'b0, ROW_PREDICT, 0, 56'd0));
	endtask

	// one input transfer; entered and left at a falling edge
	task automatic send_item(input stim_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cur_item <= s;
		in_byte  <= s.b;
		in_last  <= s.l;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// ---------------- expectations and output check ----------------

	always @(posedge clk) begin : scoreboard
		int i;
		enc_res_t got;
		enc_res_t want;
		if (arst_n && in_valid && !in_stall) begin
			predict_step(in_byte, in_last);
			case (cur_item.kind)
				ROW_CHARS: begin
					for (i = 0; i < cur_item.n; i++)
						expected_chars.push_back({cur_item.chars[8 * (cur_item.n - 1 - i) +: 8],
							1'b1, in_last && (i == cur_item.n - 1)});
				end
				ROW_MARKER: expected_chars.push_back({CH_NUL, 1'b0, 1'b1});
				default: begin
					for (i = 0; i < step_n; i++)
						expected_chars.push_back(step_buf[i]);
				end
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {out_byte, byte_valid, out_last};
			if (expected_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output byte=%h valid=%b last=%b", $time,
					out_byte, byte_valid, out_last);
			end else begin
				want = expected_chars.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: output mismatch: expected byte=%h valid=%b last=%b, got byte=%h valid=%b last=%b",
						$time, want.ch, want.vld, want.lst, out_byte, byte_valid, out_last);
				end
			end
		end
	end

	// ---------------- output backpressure ----------------

	initial begin : sink_stall
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (drain_on || calm) begin
				out_stall <= 1'b0;
				hold_left = 0;
			end else if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				hold_left = pick_gap();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// stretches where neither side idles
	initial begin : calm_phases
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			calm = ($urandom_range(0, 3) == 0);
		end
	end

	// ends the run when no transfer happens for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// ---------------- main sequence ----------------

	initial begin : main_seq
		int pieces;
		int sel;
		int k;
		logic [7:0] v;
		stim_t s;

		// directed table: extremes, every class of byte and each corner case
		dir_tab[0]  = row("A",     1'b0, ROW_CHARS,   1, "A");
		dir_tab[1]  = row("z",     1'b0, ROW_CHARS,   1, "z");
		dir_tab[2]  = row(8'hFF,   1'b0, ROW_CHARS,   3, "%FF");
		dir_tab[3]  = row(8'h01,   1'b0, ROW_CHARS,   3, "%01");
		dir_tab[4]  = row(8'h0B,   1'b0, ROW_CHARS,   1, "+");
		dir_tab[5]  = row(" ",     1'b0, ROW_CHARS,   1, "+");
		// complete triple, both cases of hex digit
		dir_tab[6]  = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[7]  = row("4",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[8]  = row("1",     1'b0, ROW_CHARS,   1, "A");
		dir_tab[9]  = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[10] = row("a",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[11] = row("F",     1'b1, ROW_CHARS,   3, "%AF");
		// incomplete triple at end of string
		dir_tab[12] = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[13] = row("7",     1'b1, ROW_CHARS,   4, "%257");
		dir_tab[14] = row(CH_PCT,  1'b1, ROW_CHARS,   3, "%25");
		// broken triples
		dir_tab[15] = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[16] = row("G",     1'b0, ROW_CHARS,   4, "%25G");
		dir_tab[17] = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[18] = row("e",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[19] = row("!",     1'b0, ROW_CHARS,   7, "%25e%21");
		// decoded zero, then the rest of the string is dropped
		dir_tab[20] = row(CH_PCT,  1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[21] = row("0",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[22] = row("0",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[23] = row("B",     1'b0, ROW_PREDICT, 0, 56'd0);
		dir_tab[24] = row("9",     1'b1, ROW_MARKER,  0, 56'd0);

		// random strings mixing well-formed triples with other bytes
		while (rand_q.size() < RAND_ITEMS) begin
			pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
			for (k = 0; k < pieces; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 40) begin
					v = ($urandom_range(0, 19) == 0) ? CH_NUL : 8'($urandom_range(0, 255));
					push_rand(CH_PCT);
					push_rand(rand_hex_char(v[7:4]));
					push_rand(rand_hex_char(v[3:0]));
				end else if (sel < 55) begin
					push_rand(CH_PCT);
					if ($urandom_range(0, 1))
						push_rand(rand_hex_char(4'($urandom_range(0, 15))));
				end else if (sel < 65) begin
					push_rand(($urandom_range(0, 5) == 0) ? " " : 8'h09 + 8'($urandom_range(0, 4)));
				end else begin
					push_rand(8'($urandom_range(1, 255)));
				end
			end
			s = rand_q.pop_back();
			s.l = 1'b1;
			rand_q.push_back(s);
		end

		// reset
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < 25; k++)
			send_item(dir_tab[k]);
		for (k = 0; k < rand_q.size(); k++)
			send_item(rand_q[k]);
		in_valid <= 1'b0;

		// let the queue drain, then watch for stray outputs
		while (expected_chars.size() != 0) @(posedge clk);
		drain_on = 1'b1;
		repeat (DRAIN_TICKS) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
